// ===== rtl/wrps_pkg.sv =====
// Package for the weighted random provider select unit.
// Holds table sizing constants, command/status codes, request/response
// structs and the sequencer state type. No dependencies.
package wrps_pkg;

  // Table sizing
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned WEIGHT_BITS = 16;

  // Fixed field widths of the request and response
  localparam int unsigned ID_W     = 31;
  localparam int unsigned WGT_IN_W = 16;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned SLOT_OW  = 4;
  localparam int unsigned CNT_OW   = 5;

  // Derived widths
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW_W   = (WEIGHT_BITS < WGT_IN_W) ? WEIGHT_BITS : WGT_IN_W;
  localparam int unsigned RUN_W  = SW_W + CNT_W;
  localparam int unsigned CMP_W  = (RUN_W > SUM_W) ? RUN_W : SUM_W;
  localparam int unsigned STEP_W = $clog2(ID_W);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_PICK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [ID_W-1:0]       server_id;
    logic [ID_W-1:0]       provider_id;
    logic [WGT_IN_W-1:0]   weight;
    logic [ID_W-1:0]       random_value;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [ID_W-1:0]       picked_server;
    logic [ID_W-1:0]       picked_provider;
    logic [WGT_IN_W-1:0]   picked_weight;
    logic [SLOT_OW-1:0]    picked_slot;
    logic [CNT_OW-1:0]     entries_now;
    logic [SUM_W-1:0]      total_weight;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0] server;
    logic [ID_W-1:0] provider;
    logic [SW_W-1:0] weight;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_WALK_RD,
    S_WALK_CHK,
    S_FETCH_RD,
    S_FETCH_CAP,
    S_RM_RD,
    S_RM_CHK,
    S_DONE
  } state_e;

endpackage

// ===== rtl/wrps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the provider entry table. No dependencies.
module wrps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/weighted_random_provider_select_unit.sv =====
// Weighted random provider select unit: entry table, weight total, and a
// sequencer around one restoring divider and one table read port.
// Clear, add and pick on an empty table go straight to the response; remove reads and
// compacts every entry; pick takes the random value modulo the total (one quotient bit a
// cycle), then walks the entries up to the chosen one, or fetches the first entry when the total is at most one.
// One request at a time: the next one is taken once the response has entered its register.
// Reset clears entry count, weight total and handshake state; table contents stay undefined.
module weighted_random_provider_select_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wrps_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wrps_pkg::rsp_t out_rsp_o
);

  import wrps_pkg::*;

  state_e              state_q, state_d;
  req_t                req_q, req_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    keep_q, keep_d;
  logic [SUM_W-1:0]    rem_q, rem_d;
  logic [ID_W-1:0]     dvd_q, dvd_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CMP_W-1:0]    run_q, run_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  entry_t              pick_q, pick_d;
  status_e             status_q, status_d;
  logic                hit_q, hit_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_rsp_q, out_rsp_d;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;
  entry_t              add_entry;

  logic [SUM_W:0]      rem_sh;
  logic [SUM_W:0]      rem_diff;
  logic [CMP_W-1:0]    run_nx;
  logic                rm_match;

  wrps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Build an entry from the incoming add request, weight cut to its stored width
  assign add_entry.server   = in_req_i.server_id;
  assign add_entry.provider = in_req_i.provider_id;
  assign add_entry.weight   = SW_W'(in_req_i.weight);

  // Divider step: shift in one dividend bit, trial subtract the total
  assign rem_sh   = {rem_q, dvd_q[ID_W-1]};
  assign rem_diff = rem_sh - {1'b0, sum_q};

  // Running weight for the pick walk
  assign run_nx = run_q + CMP_W'(rd_entry.weight);

  // Remove match: same server, and same provider unless the provider is zero
  assign rm_match = (rd_entry.server == req_q.server_id) &&
                    ((req_q.provider_id == '0) || (rd_entry.provider == req_q.provider_id));

  // Sequencer next state and datapath
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    step_d      = step_q;
    run_d       = run_q;
    slot_d      = slot_q;
    pick_d      = pick_q;
    status_d    = status_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = keep_q[IDX_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          status_d = ST_OK;
          hit_d    = 1'b0;
          idx_d    = '0;
          keep_d   = '0;
          run_d    = '0;
          unique case (in_req_i.cmd)
            CMD_CLEAR: begin
              cnt_d   = '0;
              sum_d   = '0;
              state_d = S_DONE;
            end
            CMD_ADD: begin
              if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[IDX_W-1:0];
                ram_wdata = add_entry;
                cnt_d     = cnt_q + CNT_W'(1);
                sum_d     = sum_q + SUM_W'(add_entry.weight);
              end
              state_d = S_DONE;
            end
            CMD_REMOVE: begin
              state_d = S_RM_RD;
            end
            CMD_PICK: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else if (sum_q <= SUM_W'(1)) begin
                slot_d  = '0;
                state_d = S_FETCH_RD;
              end else begin
                rem_d   = '0;
                dvd_d   = in_req_i.random_value;
                step_d  = '0;
                state_d = S_DIV;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // One quotient bit a cycle; only the remainder is kept
      S_DIV: begin
        rem_d  = rem_diff[SUM_W] ? rem_sh[SUM_W-1:0] : rem_diff[SUM_W-1:0];
        dvd_d  = dvd_q << 1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ID_W - 1)) begin
          state_d = S_WALK_RD;
        end
      end

      // Read the next entry, or fall back to the first one past the end
      S_WALK_RD: begin
        if (idx_q == cnt_q) begin
          slot_d  = '0;
          state_d = S_FETCH_RD;
        end else begin
          state_d = S_WALK_CHK;
        end
      end

      S_WALK_CHK: begin
        if (run_nx > CMP_W'(rem_q)) begin
          pick_d  = rd_entry;
          slot_d  = idx_q[IDX_W-1:0];
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          run_d   = run_nx;
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_WALK_RD;
        end
      end

      S_FETCH_RD: begin
        ram_raddr = slot_q;
        state_d   = S_FETCH_CAP;
      end

      S_FETCH_CAP: begin
        pick_d  = rd_entry;
        hit_d   = 1'b1;
        state_d = S_DONE;
      end

      // Compact in order: drop matches, move survivors down to the keep slot
      S_RM_RD: begin
        if (idx_q == cnt_q) begin
          cnt_d   = keep_q;
          state_d = S_DONE;
        end else begin
          state_d = S_RM_CHK;
        end
      end

      S_RM_CHK: begin
        if (rm_match) begin
          sum_d = sum_q - SUM_W'(rd_entry.weight);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = keep_q[IDX_W-1:0];
          ram_wdata = rd_entry;
          keep_d    = keep_q + CNT_W'(1);
        end
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_RM_RD;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_rsp_d             = '0;
          out_rsp_d.status      = status_q;
          out_rsp_d.entries_now = CNT_OW'(cnt_q);
          out_rsp_d.total_weight = sum_q;
          if (hit_q) begin
            out_rsp_d.picked_server   = pick_q.server;
            out_rsp_d.picked_provider = pick_q.provider;
            out_rsp_d.picked_weight   = WGT_IN_W'(pick_q.weight);
            out_rsp_d.picked_slot     = SLOT_OW'(slot_q);
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    idx_q     <= idx_d;
    keep_q    <= keep_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    step_q    <= step_d;
    run_q     <= run_d;
    slot_q    <= slot_d;
    pick_q    <= pick_d;
    status_q  <= status_d;
    hit_q     <= hit_d;
    out_rsp_q <= out_rsp_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== test/wrps_table_checker.sv =====
// Checker for the weighted random provider select unit: watches the
// request and response channels, keeps its own copy of the provider table and compares
// every response in order. Depends on wrps_pkg.
module wrps_table_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  wrps_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  wrps_pkg::rsp_t out_rsp_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wrps_pkg::*;

  localparam logic [31:0] W_MASK   = 32'((64'd1 << WEIGHT_BITS) - 1);
  localparam logic [31:0] SUM_MASK = 32'((64'd1 << SUM_W) - 1);

  // Shadow of the provider table
  logic [ID_W-1:0] shadow_server   [TABLE_DEPTH];
  logic [ID_W-1:0] shadow_provider [TABLE_DEPTH];
  logic [31:0]     shadow_weight   [TABLE_DEPTH];
  int unsigned     shadow_count;
  logic [31:0]     shadow_sum;

  rsp_t expected_rsps[$];
  int   mismatch_count;

  assign fail_count_o = mismatch_count;
  assign pending_o    = expected_rsps.size();

  // Apply one request to the shadow table and build the response it causes
  function automatic rsp_t predict_table_rsp(input req_t rq);
    rsp_t             rs;
    logic [31:0]      wgt;
    int unsigned      keep;
    int unsigned      chosen;
    logic [31:0]      pick_idx;
    longint unsigned  run;
    rs        = '0;
    rs.status = ST_OK;
    wgt       = 32'(rq.weight) & W_MASK;
    case (rq.cmd)
      CMD_CLEAR: begin
        shadow_count = 0;
        shadow_sum   = '0;
      end
      CMD_ADD: begin
        if (shadow_count >= TABLE_DEPTH) begin
          rs.status = ST_FULL;
        end else begin
          shadow_server[shadow_count]   = rq.server_id;
          shadow_provider[shadow_count] = rq.provider_id;
          shadow_weight[shadow_count]   = wgt;
          shadow_count++;
          shadow_sum = (shadow_sum + wgt) & SUM_MASK;
        end
      end
      CMD_REMOVE: begin
        // Drop matching entries and compact the rest in order
        keep = 0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_server[i] == rq.server_id &&
              (rq.provider_id == '0 || shadow_provider[i] == rq.provider_id)) begin
            shadow_sum = (shadow_sum - shadow_weight[i]) & SUM_MASK;
          end else begin
            shadow_server[keep]   = shadow_server[i];
            shadow_provider[keep] = shadow_provider[i];
            shadow_weight[keep]   = shadow_weight[i];
            keep++;
          end
        end
        shadow_count = keep;
      end
      default: begin
        if (shadow_count == 0) begin
          rs.status = ST_EMPTY;
        end else begin
          // Walk the running weights; fall back to the first entry
          chosen = 0;
          if (shadow_sum > 1) begin
            pick_idx = 32'(rq.random_value) % shadow_sum;
            run      = 0;
            for (int unsigned i = 0; i < shadow_count; i++) begin
              run += shadow_weight[i];
              if (run > pick_idx) begin
                chosen = i;
                break;
              end
            end
          end
          rs.picked_server   = shadow_server[chosen];
          rs.picked_provider = shadow_provider[chosen];
          rs.picked_weight   = shadow_weight[chosen][WGT_IN_W-1:0];
          rs.picked_slot     = chosen[SLOT_OW-1:0];
        end
      end
    endcase
    rs.entries_now  = shadow_count[CNT_OW-1:0];
    rs.total_weight = shadow_sum[SUM_W-1:0];
    return rs;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Compare accepted responses first, then record the accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t pred;
    if (!rst_ni) begin
      shadow_count = 0;
      shadow_sum   = '0;
      expected_rsps.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          mismatch_count++;
          $display("%0t: response with none expected, actual %p", $time, out_rsp_i);
        end else begin
          want = expected_rsps.pop_front();
          check_field("status", 32'(want.status), 32'(out_rsp_i.status));
          check_field("picked_server", 32'(want.picked_server),
                      32'(out_rsp_i.picked_server));
          check_field("picked_provider", 32'(want.picked_provider),
                      32'(out_rsp_i.picked_provider));
          check_field("picked_weight", 32'(want.picked_weight),
                      32'(out_rsp_i.picked_weight));
          check_field("picked_slot", 32'(want.picked_slot), 32'(out_rsp_i.picked_slot));
          check_field("entries_now", 32'(want.entries_now), 32'(out_rsp_i.entries_now));
          check_field("total_weight", 32'(want.total_weight),
                      32'(out_rsp_i.total_weight));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pred          = predict_table_rsp(in_req_i);
        expected_rsps = {expected_rsps, pred};
      end
    end
  end

  initial mismatch_count = 0;

endmodule

// ===== test/tb.sv =====
// Top of the weighted random provider select testbench: clock, reset,
// request stimulus, response back-pressure and the verdict.
// Depends on wrps_pkg, the unit under test and wrps_table_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wrps_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_ITEMS  = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [WGT_IN_W-1:0] WGT_MAX = '1;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  int fail_count;
  int pending;
  int sender_idle_pct = 20;
  bit quiet           = 1'b0;
  bit hold_start      = 1'b0;
  int stall_left      = 0;
  int cycle_count     = 0;

  weighted_random_provider_select_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  wrps_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_i    (out_rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Response back-pressure: random bursts, one long hold-off on demand
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet && rst_ni && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one request, with an optional idle burst first; hold until accepted
  task automatic send_req(input req_t item);
    int gap;
    @(negedge clk_i);
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait for every outstanding response
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic req_t build_req(input cmd_e c, input logic [ID_W-1:0] sid,
                                     input logic [ID_W-1:0] pid,
                                     input logic [WGT_IN_W-1:0] wgt,
                                     input logic [ID_W-1:0] rnd);
    req_t r;
    r.cmd          = c;
    r.server_id    = sid;
    r.provider_id  = pid;
    r.weight       = wgt;
    r.random_value = rnd;
    return r;
  endfunction

  // Ids mostly from a small pool so removes find matches
  function automatic logic [ID_W-1:0] pick_id(input int zero_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < zero_pct) return '0;
    if (sel < 85) return ID_W'($urandom_range(1, 4));
    if (sel < 90) return ID_MAX;
    return ID_W'($urandom);
  endfunction

  function automatic logic [WGT_IN_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WGT_IN_W'(1);
      2:       return WGT_MAX;
      3, 4:    return WGT_IN_W'($urandom_range(1, 20));
      default: return WGT_IN_W'($urandom);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_random();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ID_MAX;
      2:       return ID_W'($urandom_range(0, 64));
      default: return ID_W'($urandom);
    endcase
  endfunction

  // Random request under a command profile: balanced, fill-heavy or drain-heavy
  function automatic req_t random_req(input int profile);
    int   roll;
    cmd_e c;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      c = CMD_CLEAR;
    end else begin
      case (profile)
        1:       c = (roll < 72) ? CMD_ADD : (roll < 82) ? CMD_REMOVE : CMD_PICK;
        2:       c = (roll < 25) ? CMD_ADD : (roll < 50) ? CMD_REMOVE : CMD_PICK;
        default: c = (roll < 42) ? CMD_ADD : (roll < 60) ? CMD_REMOVE : CMD_PICK;
      endcase
    end
    return build_req(c, pick_id(3), (c == CMD_REMOVE) ? pick_id(40) : pick_id(5),
                     pick_weight(), pick_random());
  endfunction

  initial begin
    int profile;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, zero and unit totals, full table, id extremes
    send_req(build_req(CMD_CLEAR, '0, '0, '0, '0));
    send_req(build_req(CMD_PICK, '0, '0, '0, ID_MAX));
    send_req(build_req(CMD_ADD, ID_W'(5), ID_W'(1), '0, '0));
    send_req(build_req(CMD_PICK, '0, '0, '0, ID_W'(7)));
    send_req(build_req(CMD_ADD, ID_W'(6), ID_W'(2), WGT_IN_W'(1), '0));
    send_req(build_req(CMD_PICK, '0, '0, '0, ID_MAX));
    send_req(build_req(CMD_CLEAR, ID_MAX, ID_MAX, WGT_MAX, ID_MAX));
    send_req(build_req(CMD_ADD, ID_MAX, ID_MAX, WGT_MAX, ID_MAX));
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      send_req(build_req(CMD_ADD, ID_W'(i % 3 + 1), ID_W'(i % 2 + 1),
                         WGT_IN_W'(i * 37), '0));
    end
    send_req(build_req(CMD_ADD, ID_W'(9), ID_W'(9), WGT_IN_W'(3), '0));
    send_req(build_req(CMD_PICK, '0, '0, '0, '0));
    send_req(build_req(CMD_PICK, '0, '0, '0, ID_MAX));
    send_req(build_req(CMD_REMOVE, ID_W'(77), '0, '0, '0));
    send_req(build_req(CMD_REMOVE, ID_W'(2), ID_W'(1), '0, '0));
    send_req(build_req(CMD_REMOVE, ID_W'(1), '0, '0, '0));
    send_req(build_req(CMD_PICK, '0, '0, '0, ID_W'($urandom)));

    // Random part in phases of varying profile and idle density
    profile = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        profile         = $urandom_range(0, 2);
        sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      end
      if (n == 400) hold_start = 1'b1;
      if (n == 900) pause_until_drained();
      if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet           = 1'b1;
        sender_idle_pct = 0;
      end
      send_req(random_req(profile));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wrps_pkg.sv
rtl/wrps_ram.sv
rtl/weighted_random_provider_select_unit.sv
test/wrps_table_checker.sv
test/tb.sv
